FILE: hw/rtl/bf5x5_pkg.sv
// Shared types, constants and weight-table functions for the 5x5 bilateral filter.
package bf5x5_pkg;

   // Fixed widths of the configuration registers and row counters.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CSR_DATA_W   = 13;

   // Register indexes on the configuration port.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Input action codes.
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Q32 bases of the exponentials: exp(-1/1250) for range, exp(-1/5000) for space.
   localparam logic [63:0] Q32_ONE    = 64'd4294967296;
   localparam logic [63:0] RANGE_BASE = 64'd4291532696;
   localparam logic [63:0] SPACE_BASE = 64'd4294108388;

   // Quotient bits produced by the divider; the result never exceeds 511.
   localparam int QUOT_W = 9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENTRE_RD,
      ST_CENTRE_WAIT,
      ST_TAP_RD,
      ST_TAP_WAIT,
      ST_TAP_ACC,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rd_centre;
      logic latch_centre;
      logic rd_tap;
      logic weigh;
      logic acc;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic border;
      logic last_tap;
      logic div_done;
      logic out_busy;
   } status_type;

   // Q32 product, rounded half up.
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b + 64'd2147483648;
      return p >> 32;
   endfunction

   // Q32 power by square and multiply; evaluated at elaboration only.
   function automatic logic [63:0] qpow(input logic [63:0] base, input logic [31:0] n);
      logic [63:0] acc;
      logic [63:0] b;
      logic [31:0] m;
      acc = Q32_ONE;
      b   = base;
      m   = n;
      for (int i = 0; i < 32; i++) begin
         if (m != 32'd0) begin
            if (m[0]) begin
               acc = (acc == Q32_ONE) ? b : qmul(acc, b);
            end
            m = m >> 1;
            if (m != 32'd0) begin
               b = qmul(b, b);
            end
         end
      end
      return acc;
   endfunction

   // Q32 value rounded to a weight of wb fraction bits.
   function automatic logic [63:0] to_weight(input logic [63:0] q, input int wb);
      logic [63:0] r;
      r = q + (64'd1 << (31 - wb));
      return r >> (32 - wb);
   endfunction

endpackage

FILE: hw/rtl/bilateral_filter_5x5.sv
// Top level of the streaming 5x5 grayscale bilateral filter.
//
// Input channel req_*: one item per pixel in raster order (req_tuser = 0) or a
// flush item (req_tuser = 1) that drains one pending output after a frame's
// last pixel. Result channel rsp_*: the filtered pixel, with rsp_tlast high on
// the last position of a frame. Results lag the input by RADIUS rows plus
// RADIUS pixels; positions within RADIUS of an edge come out as zero.
// Configuration port csr_*: index 0 is image_width, index 1 is image_height;
// any write restarts the stream position counters.
// Throughput: the block works on one item at a time. An item with no result
// is the shortest, an item with a border result goes straight to the output
// register, and an interior result is set by the read, weigh and accumulate
// walk over the window through the single line store read port, followed by
// a restoring divider.
// Reset sets the image size to 640x480 and clears the stream counters; the line store
// needs no clearing because every window read hits a pixel of the current frame.
// When the receiver stalls, the result waits in the output register while the
// next item is still accepted; the block holds off further input only once a
// second result is ready and the register is still full.
module bilateral_filter_5x5
   import bf5x5_pkg::*;
#(
   parameter int DIAMETER    = 5,
   parameter int MAX_WIDTH   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] pixel
   input  logic [0:0]            req_tuser,   // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_pixel
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   bf5x5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bf5x5_datapath #(
      .DIAMETER    (DIAMETER),
      .MAX_WIDTH   (MAX_WIDTH),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_action    (req_tuser[0]),
      .req_pixel     (req_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_pixel     (rsp_tdata),
      .rsp_frame_end (rsp_tlast)
   );

endmodule

FILE: hw/rtl/bf5x5_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bf5x5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 5120
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bf5x5_ctrl.sv
// Controller state machine that sequences accept, window gather, division and output.
module bf5x5_ctrl
   import bf5x5_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && sts.emit) begin
               state_in = sts.border ? ST_FINISH : ST_CENTRE_RD;
            end
         end
         ST_CENTRE_RD:   state_in = ST_CENTRE_WAIT;
         ST_CENTRE_WAIT: state_in = ST_TAP_RD;
         ST_TAP_RD:      state_in = ST_TAP_WAIT;
         ST_TAP_WAIT:    state_in = ST_TAP_ACC;
         ST_TAP_ACC: begin
            state_in = sts.last_tap ? ST_DIV_INIT : ST_TAP_RD;
         end
         ST_DIV_INIT:    state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_CENTRE_RD:   cmd.rd_centre    = 1'b1;
         ST_CENTRE_WAIT: cmd.latch_centre = 1'b1;
         ST_TAP_RD:      cmd.rd_tap       = 1'b1;
         ST_TAP_WAIT:    cmd.weigh        = 1'b1;
         ST_TAP_ACC:     cmd.acc          = 1'b1;
         ST_DIV_INIT:    cmd.div_init     = 1'b1;
         ST_DIV:         cmd.div_step     = 1'b1;
         ST_FINISH:      cmd.finish       = !sts.out_busy;
         default:        cmd              = '0;
      endcase
   end

endmodule

FILE: hw/rtl/bf5x5_datapath.sv
// Datapath: stream counters, line store, weight tables, accumulators, divider, output register.
module bf5x5_datapath
   import bf5x5_pkg::*;
#(
   parameter int DIAMETER    = 5,
   parameter int MAX_WIDTH   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              sts,
   input  logic                    req_action,
   input  logic [7:0]              req_pixel,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_pixel,
   output logic                    rsp_frame_end
);

   localparam int R     = DIAMETER / 2;
   localparam int WIN   = 2 * R + 1;
   localparam int TAPS  = WIN * WIN;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int SLW   = $clog2(WIN);
   localparam int TW    = $clog2(TAPS);
   localparam int DEPTH = WIN * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int WW    = WEIGHT_BITS + 1;
   localparam int WTW   = 2 * WW;
   localparam int DW    = WTW + $clog2(TAPS + 1);
   localparam int NW    = DW + 8;
   localparam int RMW   = NW + 1;
   localparam int QBW   = $clog2(QUOT_W);

   typedef logic [255:0][WW-1:0]  range_tab_type;
   typedef logic [TAPS-1:0][WW-1:0] space_tab_type;

   // Range weight by absolute difference.
   function automatic range_tab_type build_range();
      range_tab_type t;
      logic [63:0]   q;
      for (int i = 0; i < 256; i++) begin
         q    = to_weight(qpow(RANGE_BASE, 32'(i * i)), WEIGHT_BITS);
         t[i] = q[WW-1:0];
      end
      return t;
   endfunction

   // Spatial weight by squared distance from the centre.
   function automatic space_tab_type build_space();
      space_tab_type t;
      logic [63:0]   q;
      int            a;
      int            b;
      for (int dy = 0; dy < WIN; dy++) begin
         for (int dx = 0; dx < WIN; dx++) begin
            a = dy - R;
            b = dx - R;
            q = to_weight(qpow(SPACE_BASE, 32'(a * a + b * b)), WEIGHT_BITS);
            t[dy * WIN + dx] = q[WW-1:0];
         end
      end
      return t;
   endfunction

   localparam range_tab_type RANGE_TAB = build_range();
   localparam space_tab_type SPACE_TAB = build_space();

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [CW-1:0]           col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [SLW-1:0]          slot_ff;
   logic [PW-1:0]           pend_ff;
   logic [CW-1:0]           ecol_ff;
   logic [ROW_W-1:0]        erow_ff;
   logic [SLW-1:0]          eslot_ff;

   logic [7:0]              centre_ff;
   logic [7:0]              v_ff;
   logic [WTW-1:0]          wt_ff;
   logic [NW-1:0]           num_ff;
   logic [DW-1:0]           den_ff;
   logic [SLW-1:0]          dx_ff;
   logic [TW-1:0]           k_ff;
   logic [SLW-1:0]          tslot_ff;
   logic [RMW-1:0]          rem_ff;
   logic [QUOT_W-1:0]       quot_ff;
   logic [QBW-1:0]          qbit_ff;

   logic                    out_valid_ff;
   logic [7:0]              out_pixel_ff;
   logic                    out_last_ff;

   logic [CW-1:0]           eff_w;
   logic [ROW_W-1:0]        eff_h;
   logic [PW-1:0]           lag;
   logic                    border;
   logic                    frame_end;
   logic                    emit;
   logic                    is_pixel;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [7:0]              rd_data;
   logic [7:0]              diff;
   logic [SLW:0]            top_slot;
   logic [RMW-1:0]          trial;
   logic [7:0]              result;

   // Effective image size, clamped to the supported range.
   always_comb begin
      if (32'(width_ff) < DIAMETER) begin
         eff_w = CW'(DIAMETER);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(width_ff);
      end
      if (32'(height_ff) < DIAMETER) begin
         eff_h = ROW_W'(DIAMETER);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // Emit decision, border test and frame end for the next output position.
   always_comb begin
      lag       = PW'(R * 32'(eff_w) + R);
      is_pixel  = (req_action == ACT_PIXEL);
      border    = (32'(erow_ff) < R) || (32'(erow_ff) + R >= 32'(eff_h)) ||
                  (32'(ecol_ff) < R) || (32'(ecol_ff) + R >= 32'(eff_w));
      frame_end = (erow_ff == eff_h - ROW_W'(1)) && (ecol_ff == eff_w - CW'(1));
      if (is_pixel) begin
         emit = (pend_ff >= lag);
      end else begin
         emit = (col_ff == '0) && (row_ff == '0) && (pend_ff != '0);
      end
   end

   // Line store addressing.
   always_comb begin
      top_slot = {1'b0, eslot_ff} + (SLW + 1)'(WIN - R);
      if (32'(top_slot) >= WIN) begin
         top_slot = top_slot - (SLW + 1)'(WIN);
      end
      wr_addr = AW'(32'(slot_ff) * MAX_WIDTH) + AW'(col_ff);
      if (cmd.rd_centre) begin
         rd_addr = AW'(32'(eslot_ff) * MAX_WIDTH) + AW'(ecol_ff);
      end else begin
         rd_addr = AW'(32'(tslot_ff) * MAX_WIDTH) +
                   AW'(ecol_ff - CW'(R) + CW'(dx_ff));
      end
   end

   bf5x5_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.accept && is_pixel),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration registers and stream position counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
         pend_ff   <= '0;
         ecol_ff   <= '0;
         erow_ff   <= '0;
         eslot_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_wdata[WIDTH_REG_W-1:0];
         end else begin
            height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
         end
         col_ff   <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
         pend_ff  <= '0;
         ecol_ff  <= '0;
         erow_ff  <= '0;
         eslot_ff <= '0;
      end else begin
         // Input position and pending count advance on an accepted item.
         if (cmd.accept) begin
            if (is_pixel) begin
               if (col_ff + CW'(1) >= eff_w) begin
                  col_ff <= '0;
                  if (row_ff + ROW_W'(1) >= eff_h) begin
                     row_ff  <= '0;
                     slot_ff <= '0;
                  end else begin
                     row_ff  <= row_ff + ROW_W'(1);
                     slot_ff <= (32'(slot_ff) == WIN - 1) ? '0 : slot_ff + SLW'(1);
                  end
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
               if (!emit) begin
                  pend_ff <= pend_ff + PW'(1);
               end
            end else if (emit) begin
               pend_ff <= pend_ff - PW'(1);
            end
         end
         // Output position advances once the result is loaded.
         if (cmd.finish) begin
            if (ecol_ff + CW'(1) >= eff_w) begin
               ecol_ff <= '0;
               if (erow_ff + ROW_W'(1) >= eff_h) begin
                  erow_ff  <= '0;
                  eslot_ff <= '0;
               end else begin
                  erow_ff  <= erow_ff + ROW_W'(1);
                  eslot_ff <= (32'(eslot_ff) == WIN - 1) ? '0 : eslot_ff + SLW'(1);
               end
            end else begin
               ecol_ff <= ecol_ff + CW'(1);
            end
         end
      end
   end

   // Window walk and weighted accumulation.
   always_ff @(posedge clock) begin
      if (cmd.latch_centre) begin
         centre_ff <= rd_data;
         num_ff    <= '0;
         den_ff    <= '0;
         dx_ff     <= '0;
         k_ff      <= '0;
         tslot_ff  <= top_slot[SLW-1:0];
      end
      if (cmd.weigh) begin
         v_ff  <= rd_data;
         wt_ff <= WTW'(RANGE_TAB[diff]) * WTW'(SPACE_TAB[k_ff]);
      end
      if (cmd.acc) begin
         num_ff <= num_ff + NW'(wt_ff) * NW'(v_ff);
         den_ff <= den_ff + DW'(wt_ff);
         k_ff   <= k_ff + TW'(1);
         if (32'(dx_ff) == WIN - 1) begin
            dx_ff    <= '0;
            tslot_ff <= (32'(tslot_ff) == WIN - 1) ? '0 : tslot_ff + SLW'(1);
         end else begin
            dx_ff <= dx_ff + SLW'(1);
         end
      end
   end

   assign diff = (rd_data > centre_ff) ? rd_data - centre_ff : centre_ff - rd_data;

   // Restoring divider, one quotient bit per cycle from the top.
   assign trial = RMW'(den_ff) << qbit_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= RMW'(num_ff) + RMW'(den_ff >> 1);
         quot_ff <= '0;
         qbit_ff <= QBW'(QUOT_W - 1);
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff           <= rem_ff - trial;
            quot_ff[qbit_ff] <= 1'b1;
         end
         qbit_ff <= qbit_ff - QBW'(1);
      end
   end

   assign result = (quot_ff > QUOT_W'(255)) ? 8'd255 : quot_ff[7:0];

   // Output register: holds one result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_pixel_ff <= border ? 8'd0 : result;
         out_last_ff  <= frame_end;
      end
   end

   assign sts.emit     = emit;
   assign sts.border   = border;
   assign sts.last_tap = (32'(k_ff) == TAPS - 1);
   assign sts.div_done = (qbit_ff == '0);
   assign sts.out_busy = out_valid_ff && !rsp_tready;

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_pixel     = out_pixel_ff;
   assign rsp_frame_end = out_last_ff;

endmodule
